### src/ctq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ticket queue package
// Shared types, codes and constants of the class matching ticket queue.
// ----------------------------------------------------------------------------
package ctq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;
    localparam int NUMBER_BITS_DEFAULT = 16;
    localparam int OUT_NUMBER_BITS     = 16;

    localparam int TELLERS      = 4;
    localparam int TELLER_IDX_W = $clog2(TELLERS);
    localparam int CLASS_W      = 2;

    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    localparam logic [CLASS_W-1:0] CLASS_COMMON   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_PRIORITY = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_FAST     = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_INVALID  = 2'd3;

    // Teller register reset values, entry 0 belongs to teller 0.
    localparam logic [TELLERS-1:0][CLASS_W-1:0] TELLER_CLASS_RESET =
        {CLASS_FAST, CLASS_COMMON, CLASS_COMMON, CLASS_PRIORITY};

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_SERVE   = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_ISSUED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_SERVED  = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_INVALID = 3'd4
    } status_t;

    typedef struct packed
    {
        op_t                      op;
        logic [CLASS_W-1:0]       ticket_class;
        logic [TELLER_IDX_W-1:0]  teller;
    } req_item_t;

    typedef struct packed
    {
        status_t                     status;
        logic [OUT_NUMBER_BITS-1:0]  out_number;
        logic [CLASS_W-1:0]          out_class;
    } rsp_item_t;

    // Classified command handed from the front end to the execution side.
    typedef struct packed
    {
        op_t                 op;
        logic [CLASS_W-1:0]  ticket_class;
        logic [CLASS_W-1:0]  want_class;
    } cmd_t;

endpackage
`default_nettype wire

### src/ctq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ticket queue front end
// Holds the teller registers, accepts requests and resolves the class wanted.
// ----------------------------------------------------------------------------
module ctq_front
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ctq_pkg::TELLER_IDX_W-1:0]   cfg_index,
    input  wire logic [ctq_pkg::CLASS_W-1:0]        cfg_data,
    input  wire logic                               req_valid,
    input  wire ctq_pkg::req_item_t                 req,
    output logic                                    req_stall,
    output logic                                    cmd_valid,
    output ctq_pkg::cmd_t                           cmd,
    input  wire logic                               cmd_stall
);

    logic [ctq_pkg::TELLERS-1:0][ctq_pkg::CLASS_W-1:0] teller_class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            teller_class_reg <= ctq_pkg::TELLER_CLASS_RESET;
        end
        else if (cfg_we)
        begin
            teller_class_reg[cfg_index] <= cfg_data;
        end
    end

    // The teller lookup is done here, so the back end only compares classes.
    always_comb
    begin
        cmd_valid        = req_valid;
        cmd.op           = req.op;
        cmd.ticket_class = req.ticket_class;
        cmd.want_class   = teller_class_reg[req.teller];
        req_stall        = cmd_stall;
    end

endmodule
`default_nettype wire

### src/ctq_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ticket queue command FIFO
// Short queue between the front end and the execution side.
// ----------------------------------------------------------------------------
module ctq_cmd_fifo
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_valid,
    input  wire ctq_pkg::cmd_t   wr_cmd,
    output logic                 wr_stall,
    output logic                 rd_valid,
    output ctq_pkg::cmd_t        rd_cmd,
    input  wire logic            rd_pop
);

    ctq_pkg::cmd_t                    entry_reg [ctq_pkg::CMD_FIFO_DEPTH];
    logic [ctq_pkg::CMD_PTR_W-1:0]    wr_ptr_reg;
    logic [ctq_pkg::CMD_PTR_W-1:0]    wr_ptr_next;
    logic [ctq_pkg::CMD_PTR_W-1:0]    rd_ptr_reg;
    logic [ctq_pkg::CMD_PTR_W-1:0]    rd_ptr_next;
    logic [ctq_pkg::CMD_CNT_W-1:0]    count_reg;
    logic [ctq_pkg::CMD_CNT_W-1:0]    count_next;
    logic                             push;
    logic                             pop;

    always_comb
    begin
        wr_stall = (count_reg == ctq_pkg::CMD_CNT_W'(ctq_pkg::CMD_FIFO_DEPTH));
        rd_valid = (count_reg != '0);
        rd_cmd   = entry_reg[rd_ptr_reg];
        push     = wr_valid && !wr_stall;
        pop      = rd_pop && rd_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ctq_pkg::CMD_PTR_W'(ctq_pkg::CMD_FIFO_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ctq_pkg::CMD_PTR_W'(ctq_pkg::CMD_FIFO_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule
`default_nettype wire

### src/ctq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ticket queue execution side
// Row of ticket cells with per-cell class compare, priority pick and
// one-place compaction, plus the registered result stage.
// ----------------------------------------------------------------------------
module ctq_back
#(
    parameter int QUEUE_DEPTH = ctq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int NUMBER_BITS = ctq_pkg::NUMBER_BITS_DEFAULT
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    input  wire ctq_pkg::cmd_t   cmd,
    output logic                 cmd_pop,
    output logic                 rsp_valid,
    output ctq_pkg::rsp_item_t   rsp,
    input  wire logic            rsp_stall
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [NUMBER_BITS-1:0]       num_reg [QUEUE_DEPTH];
    logic [ctq_pkg::CLASS_W-1:0]  cls_reg [QUEUE_DEPTH];

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [NUMBER_BITS-1:0]       number_reg;
    logic [NUMBER_BITS-1:0]       number_next;
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    ctq_pkg::rsp_item_t           rsp_reg;
    ctq_pkg::rsp_item_t           rsp_next;

    logic                         take;
    logic                         full;
    logic                         empty;
    logic                         do_enq;
    logic                         do_serve;
    logic [QUEUE_DEPTH-1:0]       match;
    logic [IDX_W-1:0]             pos;
    logic                         found;

    always_comb
    begin
        take  = cmd_valid && (!rsp_valid_reg || !rsp_stall);
        full  = (count_reg == CNT_W'(QUEUE_DEPTH));
        empty = (count_reg == '0);

        // Only live entries take part in the search; the oldest match wins.
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (cls_reg[i] == cmd.want_class);
        end
        pos   = '0;
        found = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (!found && match[i])
            begin
                pos   = IDX_W'(i);
                found = 1'b1;
            end
        end

        do_enq   = take && (cmd.op == ctq_pkg::OP_ENQUEUE) && !full
                   && (cmd.ticket_class != ctq_pkg::CLASS_INVALID);
        do_serve = take && (cmd.op == ctq_pkg::OP_SERVE) && !empty;

        count_next  = count_reg;
        number_next = number_reg;
        if (do_enq)
        begin
            count_next  = count_reg + 1'b1;
            number_next = number_reg + 1'b1;
        end
        else if (do_serve)
        begin
            count_next = count_reg - 1'b1;
        end

        rsp_next.status     = ctq_pkg::ST_EMPTY;
        rsp_next.out_number = '0;
        rsp_next.out_class  = '0;
        unique case (cmd.op)
            ctq_pkg::OP_ENQUEUE:
            begin
                if (full)
                begin
                    rsp_next.status = ctq_pkg::ST_FULL;
                end
                else if (cmd.ticket_class == ctq_pkg::CLASS_INVALID)
                begin
                    rsp_next.status = ctq_pkg::ST_INVALID;
                end
                else
                begin
                    rsp_next.status     = ctq_pkg::ST_ISSUED;
                    rsp_next.out_number = ctq_pkg::OUT_NUMBER_BITS'(number_reg);
                    rsp_next.out_class  = cmd.ticket_class;
                end
            end
            ctq_pkg::OP_SERVE:
            begin
                if (!empty)
                begin
                    rsp_next.status     = ctq_pkg::ST_SERVED;
                    rsp_next.out_number = ctq_pkg::OUT_NUMBER_BITS'(num_reg[pos]);
                    rsp_next.out_class  = cls_reg[pos];
                end
            end
            default:
            begin
                rsp_next.status = ctq_pkg::ST_EMPTY;
            end
        endcase

        if (take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end

        cmd_pop   = take;
        rsp_valid = rsp_valid_reg;
        rsp       = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            number_reg    <= NUMBER_BITS'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            number_reg    <= number_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Each cell either takes the new ticket at the tail or its younger
    // neighbour when a ticket at or ahead of it is removed.
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic write_here;
        assign write_here = do_enq && (count_reg[IDX_W-1:0] == IDX_W'(g));

        if (g < QUEUE_DEPTH - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (write_here)
                begin
                    num_reg[g] <= number_reg;
                    cls_reg[g] <= cmd.ticket_class;
                end
                else if (do_serve && (IDX_W'(g) >= pos))
                begin
                    num_reg[g] <= num_reg[g+1];
                    cls_reg[g] <= cls_reg[g+1];
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (write_here)
                begin
                    num_reg[g] <= number_reg;
                    cls_reg[g] <= cmd.ticket_class;
                end
            end
        end
    end

endmodule
`default_nettype wire

### src/class_matching_ticket_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Class matching ticket queue
// Arrival-ordered ticket queue whose tellers serve the oldest ticket of
// their configured class, or the head ticket when none matches.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while req_stall is low and
// answers each with exactly one result, in order. A request is moved into
// a two-entry command queue at its transfer; the execution side picks it
// up from there and loads the result register as it does, and the result
// transfers from that register. The sustained rate is one request per
// cycle while no stall holds the flow. That rate is set by the serve path,
// which compares every ticket cell with the wanted class, picks the oldest
// match and closes the gap by one place. The teller registers may be
// written only while the block holds no request.
module class_matching_ticket_queue
#(
    parameter int QUEUE_DEPTH = ctq_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int NUMBER_BITS = ctq_pkg::NUMBER_BITS_DEFAULT
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [ctq_pkg::TELLER_IDX_W-1:0]   cfg_index,
    input  wire logic [ctq_pkg::CLASS_W-1:0]        cfg_data,
    input  wire logic                               req_valid,
    input  wire ctq_pkg::req_item_t                 req,
    output logic                                    req_stall,
    output logic                                    rsp_valid,
    output ctq_pkg::rsp_item_t                      rsp,
    input  wire logic                               rsp_stall
);

    logic            front_valid;
    ctq_pkg::cmd_t   front_cmd;
    logic            front_stall;
    logic            cmd_valid;
    ctq_pkg::cmd_t   cmd;
    logic            cmd_pop;

    ctq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_stall (front_stall)
    );

    ctq_cmd_fifo u_cmd_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_cmd   (front_cmd),
        .wr_stall (front_stall),
        .rd_valid (cmd_valid),
        .rd_cmd   (cmd),
        .rd_pop   (cmd_pop)
    );

    ctq_back
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUMBER_BITS (NUMBER_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .rsp_stall (rsp_stall)
    );

    // The execution side never takes a command from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) !cmd_valid |-> !cmd_pop)
        else $error("command taken from an empty command queue");

    // Results without a ticket carry zero number and class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status != ctq_pkg::ST_ISSUED && rsp.status != ctq_pkg::ST_SERVED)
        |-> (rsp.out_number == '0 && rsp.out_class == '0))
        else $error("non-ticket result carries ticket data");

    // Tickets issued or served always hold a real class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ctq_pkg::ST_ISSUED || rsp.status == ctq_pkg::ST_SERVED))
        |-> (rsp.out_class != ctq_pkg::CLASS_INVALID))
        else $error("ticket result with invalid class");

    // A command taken always yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |=> rsp_valid)
        else $error("command taken without a result");

endmodule
`default_nettype wire
